// ===== design/svf_pkg.sv =====
`default_nettype none

package svf_pkg;

	localparam int CHANNELS        = 2;
	localparam int TANH_TABLE_BITS = 8;
	localparam int SAMPLE_BITS     = 24;

	localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FRAC_BITS = 20;
	localparam int COEF_BITS = 16;
	localparam int IW        = 32;
	localparam int MEM_W     = 2 * IW;

	localparam int MODE_W  = 2;
	localparam int DAMP_W  = 20;
	localparam int COEF_W  = 17;
	localparam int DRIVE_W = 19;
	localparam int INV_W   = 17;
	localparam int BELL_W  = 24;

	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 24;

	localparam int TAB_LEN = (1 << TANH_TABLE_BITS) + 1;
	localparam int TAB_W   = FRAC_BITS + 1;
	localparam int AX_HI   = FRAC_BITS + 3;
	localparam int FR_W    = AX_HI - TANH_TABLE_BITS;

	localparam int DIFF_W = IW + 1;
	localparam int X_W    = DIFF_W + DRIVE_W + 1 - COEF_BITS;
	localparam int T_W    = FRAC_BITS + 2;
	localparam int V3_W   = T_W + INV_W + 1 - COEF_BITS;
	localparam int V1_W   = IW + COEF_W + 2 - COEF_BITS;
	localparam int V2_W   = V1_W + 1;
	localparam int N_W    = V2_W + 2;
	localparam int RES_W  = V1_W + BELL_W + 2 - COEF_BITS;
	localparam int MA_W   = V1_W;
	localparam int MB_W   = BELL_W;
	localparam int P_W    = MA_W + MB_W;

	localparam longint unsigned Q31_ONE = 64'd1 << 31;

	typedef enum logic [MODE_W-1:0] {
		MODE_LP   = 2'd0,
		MODE_HP   = 2'd1,
		MODE_BELL = 2'd2
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_DAMPING   = 3'd1,
		REG_A1        = 3'd2,
		REG_A2        = 3'd3,
		REG_A3        = 3'd4,
		REG_DRIVE     = 3'd5,
		REG_INV_DRIVE = 3'd6,
		REG_BELL      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [DAMP_W-1:0]  damping;
		logic [COEF_W-1:0]  coef_a1;
		logic [COEF_W-1:0]  coef_a2;
		logic [COEF_W-1:0]  coef_a3;
		logic [DRIVE_W-1:0] drive;
		logic [INV_W-1:0]   inv_drive;
		logic [BELL_W-1:0]  bell_scale;
	} svf_coef_t;

	typedef struct packed {
		logic                   channel;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   fault;
	} svf_res_t;

	localparam svf_coef_t COEF_RESET = '{
		mode:       MODE_LP,
		damping:    DAMP_W'(92682),
		coef_a1:    COEF_W'(65536),
		coef_a2:    COEF_W'(0),
		coef_a3:    COEF_W'(0),
		drive:      DRIVE_W'(65536),
		inv_drive:  INV_W'(65536),
		bell_scale: BELL_W'(0)
	};

	typedef logic [TAB_W-1:0] tanh_tab_t [TAB_LEN];

	// Restoring long division, used only while the table is built.
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned dv);
		logic [64:0]     rem;
		longint unsigned quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, dv}) begin
				rem    = rem - {1'b0, dv};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// The tanh table is evaluated at elaboration: exp(-2*step) from a truncated
	// Taylor series, then repeated multiplication to walk along the grid.
	function automatic tanh_tab_t build_tanh_tab();
		tanh_tab_t tab;
		longint unsigned stp;
		longint unsigned term;
		longint unsigned e;
		longint unsigned fac;
		longint unsigned den;
		longint sum;
		stp  = 64'd1 << (35 - TANH_TABLE_BITS);
		term = Q31_ONE;
		e    = Q31_ONE;
		sum  = $signed(Q31_ONE);
		for (int n = 1; n <= 24; n++) begin
			term = udiv64((term * stp) >> 31, 64'(n));
			if (n[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		fac = $unsigned(sum);
		for (int i = 0; i < TAB_LEN; i++) begin
			den    = Q31_ONE + e;
			tab[i] = TAB_W'(udiv64(((Q31_ONE - e) << FRAC_BITS) + (den >> 1), den));
			e      = (e * fac + (Q31_ONE >> 1)) >> 31;
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

`default_nettype wire

// ===== design/svf_ram.sv =====
`default_nettype none

module svf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/svf_regs.sv =====
`default_nettype none

module svf_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [svf_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [svf_pkg::CFG_W-1:0]     cfg_data,
	output svf_pkg::svf_coef_t                 coef
);

	import svf_pkg::*;

	svf_coef_t coef_q;

	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE: begin
					coef_q.mode <= cfg_data[MODE_W-1:0];
				end
				REG_DAMPING: begin
					coef_q.damping <= cfg_data[DAMP_W-1:0];
				end
				REG_A1: begin
					coef_q.coef_a1 <= cfg_data[COEF_W-1:0];
				end
				REG_A2: begin
					coef_q.coef_a2 <= cfg_data[COEF_W-1:0];
				end
				REG_A3: begin
					coef_q.coef_a3 <= cfg_data[COEF_W-1:0];
				end
				REG_DRIVE: begin
					coef_q.drive <= cfg_data[DRIVE_W-1:0];
				end
				REG_INV_DRIVE: begin
					coef_q.inv_drive <= cfg_data[INV_W-1:0];
				end
				REG_BELL: begin
					coef_q.bell_scale <= cfg_data[BELL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/svf_core.sv =====
`default_nettype none

module svf_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            channel,
	input  wire logic [svf_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire svf_pkg::svf_coef_t              coef,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output svf_pkg::svf_res_t                    res
);

	import svf_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_RD   = 13'b0000000000010,
		ST_XAB  = 13'b0000000000100,
		ST_TRD  = 13'b0000000001000,
		ST_INTP = 13'b0000000010000,
		ST_TSEL = 13'b0000000100000,
		ST_INV  = 13'b0000001000000,
		ST_M1   = 13'b0000010000000,
		ST_M2   = 13'b0000100000000,
		ST_M3   = 13'b0001000000000,
		ST_M4   = 13'b0010000000000,
		ST_RES  = 13'b0100000000000,
		ST_WB   = 13'b1000000000000
	} state_t;

	localparam logic [T_W-1:0] T_ONE = T_W'(64'd1 << FRAC_BITS);
	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	state_t state_q, state_d;

	logic                          acc_in;
	logic                          wb_fire;
	logic [CH_AW-1:0]              ch_addr;
	logic [CHANNELS-1:0]           vld_q;

	logic                          ch_q;
	logic [CH_AW-1:0]              addr_q;
	logic signed [SAMPLE_BITS-1:0] v0_q;
	logic                          rd_vld_s1;
	logic [MEM_W-1:0]              rdata;
	logic [MEM_W-1:0]              wdata;

	logic signed [IW-1:0]          ic1_rd, ic2_rd;
	logic signed [IW-1:0]          ic1_q, ic2_q;
	logic signed [DIFF_W-1:0]      diff;

	logic signed [MA_W-1:0]        ma;
	logic signed [MB_W-1:0]        mb;
	logic signed [P_W-1:0]         prod_q;
	logic signed [P_W-1:0]         acc_q;
	logic signed [P_W:0]           psum;

	logic signed [X_W-1:0]         x_w;
	logic [X_W-1:0]                ax;
	logic                          sat_q, neg_q;
	logic [TANH_TABLE_BITS-1:0]    idx_q;
	logic [TANH_TABLE_BITS:0]      idx_lo, idx_hi;
	logic [FR_W-1:0]               frac_q;
	logic [TAB_W-1:0]              lo_q, hi_q;
	logic signed [T_W-1:0]         r_w, mag;
	logic signed [T_W-1:0]         t_q;
	logic signed [V3_W-1:0]        v3_q;
	logic signed [V1_W-1:0]        v1_q;
	logic signed [V2_W-1:0]        v2_q;

	logic signed [RES_W-1:0]       psh;
	logic signed [RES_W-1:0]       res_full;
	logic signed [N_W-1:0]         n1, n2;
	logic                          ovf;
	logic                          res_ok;
	logic [SAMPLE_BITS-1:0]        res_clamp;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc_in    = in_valid && in_ready;
	assign res_valid = (state_q == ST_WB);
	assign wb_fire   = res_valid && res_ready;

	assign ch_addr = (32'(channel) < CHANNELS) ? CH_AW'(channel) : CH_AW'(CHANNELS - 1);

	svf_ram #(
		.WIDTH(MEM_W),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk  (clk),
		.we   (wb_fire),
		.waddr(addr_q),
		.wdata(wdata),
		.re   (acc_in),
		.raddr(ch_addr),
		.rdata(rdata)
	);

	// An entry never written since reset reads as zero.
	assign ic1_rd = rd_vld_s1 ? $signed(rdata[IW-1:0]) : '0;
	assign ic2_rd = rd_vld_s1 ? $signed(rdata[MEM_W-1:IW]) : '0;
	assign diff   = DIFF_W'(v0_q) - DIFF_W'(ic2_rd);

	assign x_w    = X_W'(prod_q >>> COEF_BITS);
	assign ax     = x_w[X_W-1] ? X_W'(-x_w) : X_W'(x_w);
	assign idx_lo = {1'b0, idx_q};
	assign idx_hi = {1'b0, idx_q} + 1'b1;
	assign r_w    = T_W'($signed({1'b0, lo_q})) + T_W'(prod_q >>> FR_W);
	assign mag    = sat_q ? T_ONE : r_w;
	assign psum   = (P_W + 1)'(acc_q) + (P_W + 1)'(prod_q);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_RD: begin
				ma = MA_W'(diff);
				mb = MB_W'($signed({1'b0, coef.drive}));
			end
			ST_INTP: begin
				ma = MA_W'($signed({1'b0, hi_q}) - $signed({1'b0, lo_q}));
				mb = MB_W'($signed({1'b0, frac_q}));
			end
			ST_INV: begin
				ma = MA_W'(t_q);
				mb = MB_W'($signed({1'b0, coef.inv_drive}));
			end
			ST_M1: begin
				ma = MA_W'(ic1_q);
				mb = MB_W'($signed({1'b0, coef.coef_a1}));
			end
			ST_M2: begin
				ma = MA_W'(v3_q);
				mb = MB_W'($signed({1'b0, coef.coef_a2}));
			end
			ST_M3: begin
				ma = MA_W'(ic1_q);
				mb = MB_W'($signed({1'b0, coef.coef_a2}));
			end
			ST_M4: begin
				ma = MA_W'(v3_q);
				mb = MB_W'($signed({1'b0, coef.coef_a3}));
			end
			ST_RES, ST_WB: begin
				ma = v1_q;
				if (coef.mode == MODE_HP) begin
					mb = MB_W'($signed({1'b0, coef.damping}));
				end else begin
					mb = $signed(coef.bell_scale);
				end
			end
			default: begin
			end
		endcase
	end

	assign psh = RES_W'(prod_q >>> COEF_BITS);

	always_comb begin
		case (coef.mode)
			MODE_LP: begin
				res_full = RES_W'(v2_q);
			end
			MODE_HP: begin
				res_full = RES_W'(v0_q) - psh - RES_W'(v2_q);
			end
			MODE_BELL: begin
				res_full = RES_W'(v0_q) + psh;
			end
			default: begin
				res_full = RES_W'(v0_q) + psh;
			end
		endcase
	end

	assign n1  = N_W'(v1_q) + N_W'(v1_q) - N_W'(ic1_q);
	assign n2  = N_W'(v2_q) + N_W'(v2_q) - N_W'(ic2_q);
	assign ovf = !((&n1[N_W-1:IW-1]) || !(|n1[N_W-1:IW-1])) ||
	             !((&n2[N_W-1:IW-1]) || !(|n2[N_W-1:IW-1]));

	assign res_ok    = (&res_full[RES_W-1:SAMPLE_BITS-1]) ||
	                   !(|res_full[RES_W-1:SAMPLE_BITS-1]);
	assign res_clamp = res_ok ? res_full[SAMPLE_BITS-1:0] :
	                   (res_full[RES_W-1] ? SMIN : SMAX);

	assign wdata       = ovf ? '0 : {n2[IW-1:0], n1[IW-1:0]};
	assign res.channel = ch_q;
	assign res.sample  = ovf ? '0 : res_clamp;
	assign res.fault   = ovf;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_XAB;
			end
			ST_XAB: begin
				state_d = ST_TRD;
			end
			ST_TRD: begin
				state_d = ST_INTP;
			end
			ST_INTP: begin
				state_d = ST_TSEL;
			end
			ST_TSEL: begin
				state_d = ST_INV;
			end
			ST_INV: begin
				state_d = ST_M1;
			end
			ST_M1: begin
				state_d = ST_M2;
			end
			ST_M2: begin
				state_d = ST_M3;
			end
			ST_M3: begin
				state_d = ST_M4;
			end
			ST_M4: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (wb_fire) begin
				vld_q[addr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (acc_in) begin
			ch_q      <= channel;
			addr_q    <= ch_addr;
			v0_q      <= $signed(sample_in);
			rd_vld_s1 <= vld_q[ch_addr];
		end
		case (state_q)
			ST_RD: begin
				ic1_q <= ic1_rd;
				ic2_q <= ic2_rd;
			end
			ST_XAB: begin
				sat_q  <= |ax[X_W-1:AX_HI];
				neg_q  <= x_w[X_W-1];
				idx_q  <= ax[AX_HI-1:FR_W];
				frac_q <= ax[FR_W-1:0];
			end
			ST_TRD: begin
				lo_q <= TANH_TAB[idx_lo];
				hi_q <= TANH_TAB[idx_hi];
			end
			ST_TSEL: begin
				t_q <= neg_q ? -mag : mag;
			end
			ST_M1: begin
				v3_q <= V3_W'(prod_q >>> COEF_BITS);
			end
			ST_M2: begin
				acc_q <= prod_q;
			end
			ST_M3: begin
				v1_q <= V1_W'(psum >>> COEF_BITS);
			end
			ST_M4: begin
				acc_q <= prod_q;
			end
			ST_RES: begin
				v2_q <= V2_W'(ic2_q) + V2_W'(psum >>> COEF_BITS);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/saturating_svf_filter.sv =====
// A request is accepted only while the core is idle, and no new request is taken until
// its result is in the output register; the filter update is a chain of eight
// products through one shared multiplier with a registered output.
// Reset is asynchronous and active low: it restores the register defaults, empties the
// output register and marks both integrator entries of every channel as zero.
// No clearing pass follows reset; the block accepts a request in the first cycle.
`default_nettype none

module saturating_svf_filter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            channel,
	input  wire logic [svf_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 channel_out,
	output logic      [svf_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                 fault,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [svf_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [svf_pkg::CFG_W-1:0]       cfg_data
);

	import svf_pkg::*;

	svf_coef_t coef;
	svf_res_t  res;
	svf_res_t  out_q;
	logic      res_valid;
	logic      res_ready;
	logic      out_valid_q;

	svf_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.coef     (coef)
	);

	svf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.channel  (channel),
		.sample_in(sample_in),
		.coef     (coef),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = out_q.channel;
	assign sample_out  = out_q.sample;
	assign fault       = out_q.fault;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("A second request was accepted while one is in flight.");

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid)
		else $error("The core offers a result while it is idle.");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid)
		else $error("A handed-over result did not reach the output register.");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault) |-> (sample_out == '0))
		else $error("A faulted result carries a nonzero sample.");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import svf_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	typedef struct packed {
		logic                   ch;
		logic [SAMPLE_BITS-1:0] smp;
	} sample_req_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic                   channel     = 1'b0;
	logic [SAMPLE_BITS-1:0] sample_in   = '0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic                   channel_out;
	logic [SAMPLE_BITS-1:0] sample_out;
	logic                   fault;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [REG_IDX_W-1:0]   cfg_index   = '0;
	logic [CFG_W-1:0]       cfg_data    = '0;

	logic [MODE_W-1:0]  mode_r  = MODE_LP;
	logic [DAMP_W-1:0]  damp_r  = DAMP_W'(92682);
	logic [COEF_W-1:0]  a1_r    = COEF_W'(65536);
	logic [COEF_W-1:0]  a2_r    = '0;
	logic [COEF_W-1:0]  a3_r    = '0;
	logic [DRIVE_W-1:0] drive_r = DRIVE_W'(65536);
	logic [INV_W-1:0]   inv_r   = INV_W'(65536);
	logic [BELL_W-1:0]  bell_r  = '0;

	int z_band[CHANNELS] = '{default: 0};
	int z_low[CHANNELS]  = '{default: 0};
	longint tanh_grid[TAB_LEN];

	sample_req_t sample_queue[$];
	svf_res_t    filtered_expect[$];
	sample_req_t next_req;
	svf_res_t    oldest_expect;

	int n_pushed   = 0;
	int n_sent     = 0;
	int n_checked  = 0;
	int n_fail     = 0;
	int n_faults   = 0;
	int n_clipped  = 0;
	int n_settings = 0;
	int gap_pct    = 33;
	int stall_pct  = 70;

	saturating_svf_filter dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void build_tanh_grid();
		longint unsigned stp;
		longint unsigned term;
		longint unsigned e;
		longint unsigned fac;
		longint unsigned den;
		longint acc;
		int n;
		int i;
		stp  = 64'd1 << (35 - TANH_TABLE_BITS);
		term = Q31_ONE;
		e    = Q31_ONE;
		acc  = longint'(Q31_ONE);
		for (n = 1; n <= 24; n++) begin
			term = ((term * stp) >> 31) / 64'(n);
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		fac = $unsigned(acc);
		for (i = 0; i < TAB_LEN; i++) begin
			den          = Q31_ONE + e;
			tanh_grid[i] = longint'((((Q31_ONE - e) << FRAC_BITS) + den / 64'd2) / den);
			e            = (e * fac + Q31_ONE / 64'd2) >> 31;
		end
	endfunction

	function automatic longint soft_clip(input longint x);
		longint ax;
		longint pos;
		longint fr;
		longint lo;
		longint hi;
		longint r;
		int idx;
		ax = (x < 0) ? -x : x;
		if (ax >= (longint'(8) <<< FRAC_BITS)) begin
			r = longint'(1) <<< FRAC_BITS;
		end else begin
			pos = ax <<< TANH_TABLE_BITS;
			idx = int'(pos >>> (FRAC_BITS + 3));
			fr  = pos & ((longint'(1) <<< (FRAC_BITS + 3)) - 1);
			lo  = tanh_grid[idx];
			hi  = tanh_grid[idx + 1];
			r   = lo + (((hi - lo) * fr) >>> (FRAC_BITS + 3));
		end
		return (x < 0) ? -r : r;
	endfunction

	function automatic svf_res_t filter_step(input sample_req_t rq);
		svf_res_t r;
		int c;
		longint x;
		longint zb;
		longint zl;
		longint fb;
		longint bp;
		longint lp;
		longint nb;
		longint nl;
		longint y;
		longint ymax;
		c    = (int'(rq.ch) < CHANNELS) ? int'(rq.ch) : CHANNELS - 1;
		x    = longint'($signed(rq.smp));
		zb   = longint'(z_band[c]);
		zl   = longint'(z_low[c]);
		fb   = ((x - zl) * longint'(drive_r)) >>> COEF_BITS;
		fb   = (soft_clip(fb) * longint'(inv_r)) >>> COEF_BITS;
		bp   = (longint'(a1_r) * zb + longint'(a2_r) * fb) >>> COEF_BITS;
		lp   = zl + ((longint'(a2_r) * zb + longint'(a3_r) * fb) >>> COEF_BITS);
		nb   = 2 * bp - zb;
		nl   = 2 * lp - zl;
		ymax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		case (mode_r)
			MODE_LP: y = lp;
			MODE_HP: y = x - ((longint'(damp_r) * bp) >>> COEF_BITS) - lp;
			default: y = x + ((longint'($signed(bell_r)) * bp) >>> COEF_BITS);
		endcase
		r.channel = rq.ch;
		if (longint'(int'(nb)) != nb || longint'(int'(nl)) != nl) begin
			z_band[c] = 0;
			z_low[c]  = 0;
			r.sample  = '0;
			r.fault   = 1'b1;
		end else begin
			z_band[c] = int'(nb);
			z_low[c]  = int'(nl);
			if (y > ymax) begin
				y = ymax;
			end
			if (y < -ymax - 1) begin
				y = -ymax - 1;
			end
			r.sample = y[SAMPLE_BITS-1:0];
			r.fault  = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3: return SAMPLE_BITS'($urandom);
			default: return SAMPLE_BITS'($signed(SAMPLE_BITS'($urandom)) >>> $urandom_range(1, 8));
		endcase
	endfunction

	task automatic queue_req(input logic ch, input logic [SAMPLE_BITS-1:0] smp);
		sample_queue.push_back(sample_req_t'{ch, smp});
		n_pushed++;
	endtask

	task automatic wait_drained();
		while (n_sent != n_pushed || filtered_expect.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val, input int w);
		logic [CFG_W-1:0] junk;
		junk      = ($urandom_range(1) == 1) ? (CFG_W'($urandom) << w) : '0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val | junk;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:      mode_r  = val[MODE_W-1:0];
			REG_DAMPING:   damp_r  = val[DAMP_W-1:0];
			REG_A1:        a1_r    = val[COEF_W-1:0];
			REG_A2:        a2_r    = val[COEF_W-1:0];
			REG_A3:        a3_r    = val[COEF_W-1:0];
			REG_DRIVE:     drive_r = val[DRIVE_W-1:0];
			REG_INV_DRIVE: inv_r   = val[INV_W-1:0];
			REG_BELL:      bell_r  = val[BELL_W-1:0];
		endcase
	endtask

	task automatic set_filter(input logic [MODE_W-1:0] md, input int k, input int a1,
			input int a2, input int a3, input int drv, input int inv, input int bell);
		@(posedge clk);
		write_reg(REG_MODE, CFG_W'(md), MODE_W);
		write_reg(REG_DAMPING, CFG_W'(k), DAMP_W);
		write_reg(REG_A1, CFG_W'(a1), COEF_W);
		write_reg(REG_A2, CFG_W'(a2), COEF_W);
		write_reg(REG_A3, CFG_W'(a3), COEF_W);
		write_reg(REG_DRIVE, CFG_W'(drv), DRIVE_W);
		write_reg(REG_INV_DRIVE, CFG_W'(inv), INV_W);
		write_reg(REG_BELL, CFG_W'(bell), BELL_W);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic random_setting(input bit wild);
		logic [MODE_W-1:0] md;
		int g;
		int k;
		int a1;
		int a2;
		int a3;
		int drv;
		int inv;
		int bell;
		md = MODE_W'($urandom_range(3));
		if (wild) begin
			k    = $urandom;
			a1   = $urandom;
			a2   = $urandom;
			a3   = $urandom;
			drv  = $urandom;
			inv  = $urandom;
			bell = $urandom;
		end else begin
			// Coefficients as host software derives them from cutoff and damping.
			g    = $urandom_range(400, 150000);
			k    = $urandom_range(3000, 140000);
			a1   = int'((64'd1 << 32) / (64'd65536 + ((longint'(g) * (g + k)) >> 16)));
			a2   = int'((longint'(g) * a1) >> 16);
			a3   = int'((longint'(g) * a2) >> 16);
			drv  = $urandom_range(65536, 262144);
			inv  = int'((64'd1 << 32) / drv);
			bell = $urandom_range(0, 1 << 21) - (1 << 20);
			if ($urandom_range(3) == 0) begin
				bell = $urandom_range(1) ? int'($signed(S_MAX)) : int'($signed(S_MIN));
			end
		end
		set_filter(md, k, a1, a2, a3, drv, inv, bell);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				filtered_expect.push_back(filter_step(sample_req_t'{channel, sample_in}));
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (sample_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
					next_req = sample_queue.pop_front();
					in_valid  <= 1'b1;
					channel   <= next_req.ch;
					sample_in <= next_req.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (filtered_expect.size() == 0) begin
					$error("unexpected result: channel_out %0d sample_out %0d fault %0d",
						channel_out, $signed(sample_out), fault);
					n_fail++;
				end else begin
					oldest_expect = filtered_expect.pop_front();
					if (channel_out !== oldest_expect.channel) begin
						$error("channel_out: expected %0d, actual %0d",
							oldest_expect.channel, channel_out);
						n_fail++;
					end
					if (sample_out !== oldest_expect.sample) begin
						$error("sample_out: expected %0d, actual %0d",
							$signed(oldest_expect.sample), $signed(sample_out));
						n_fail++;
					end
					if (fault !== oldest_expect.fault) begin
						$error("fault: expected %0d, actual %0d", oldest_expect.fault, fault);
						n_fail++;
					end
					n_checked++;
					if (oldest_expect.fault) begin
						n_faults++;
					end else if (oldest_expect.sample == S_MAX || oldest_expect.sample == S_MIN) begin
						n_clipped++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		build_tanh_grid();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_req(1'b0, S_MAX);
		queue_req(1'b1, S_MIN);
		wait_drained();

		set_filter(MODE_LP, 92682, 33486, 16743, 8371, 65536, 65536, 0);
		queue_req(1'b0, S_MAX);
		queue_req(1'b0, S_MAX);
		queue_req(1'b1, S_MIN);
		queue_req(1'b0, '0);
		queue_req(1'b1, '1);
		queue_req(1'b1, SAMPLE_BITS'(1));
		wait_drained();

		set_filter(MODE_HP, 20'hFFFFF, 33486, 16743, 8371, 262144, 16384, 0);
		queue_req(1'b0, S_MIN);
		queue_req(1'b1, S_MAX);
		queue_req(1'b0, S_MAX);
		wait_drained();

		set_filter(MODE_BELL, 0, 33486, 16743, 8371, 65536, 65536, int'($signed(S_MAX)));
		queue_req(1'b0, SAMPLE_BITS'(24'h400000));
		queue_req(1'b1, S_MIN);
		queue_req(1'b0, S_MAX);
		wait_drained();

		set_filter(MODE_SPARE, 92682, 33486, 16743, 8371, 19'h7FFFF, 17'h1FFFF,
			int'($signed(S_MIN)));
		queue_req(1'b1, S_MAX);
		queue_req(1'b1, S_MIN);
		queue_req(1'b0, SAMPLE_BITS'(24'h000123));
		wait_drained();

		// An integrator gain near two makes the first integrator run away
		// within a few samples, so the overflow path is exercised.
		set_filter(MODE_LP, 0, 17'h1FFFF, 65536, 65536, 65536, 65536, 0);
		repeat (10) queue_req(1'b0, S_MAX);
		wait_drained();

		for (int p = 0; p < 9; p++) begin
			gap_pct   = (p < 3) ? 33 : (p < 6) ? 70 : 0;
			stall_pct = (p < 3) ? 70 : (p < 6) ? 33 : 0;
			random_setting(p % 4 == 3);
			repeat (50) queue_req(1'($urandom), random_sample());
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("Filtered %0d samples under %0d coefficient sets and compared %0d results.",
			n_sent, n_settings, n_checked);
		$display("Integrator overflow tripped %0d times; %0d outputs hit full scale.",
			n_faults, n_clipped);
		if (n_fail == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
design/svf_pkg.sv
design/svf_ram.sv
design/svf_regs.sv
design/svf_core.sv
design/saturating_svf_filter.sv
bench/tb.sv
